// ----- rtl/core/lccrc_pkg.sv -----
// ----------------------------------------------------------------------------
// lccrc_pkg
// Shared types and constants of the label centroid and ROI crop core: field
// widths, configuration register indexes and the command word that travels
// from the front end to the back end.
// ----------------------------------------------------------------------------
package lccrc_pkg;

    // Field widths
    localparam int COORD_W = 11;
    localparam int COLOR_W = 24;
    localparam int ROI_W   = 12;
    localparam int SUM_W   = 33;
    localparam int CNT_W   = 23;
    localparam int QUO_W   = 11;

    // Configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_COLOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROI_WIDTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROI_HEIGHT   = 2'd2;

    localparam logic [ROI_W-1:0] ROI_RESET = 12'd100;
    localparam int               ROI_LIMIT = 2048;

    // Frame size defaults
    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;

    // Command queue depth
    localparam int QUEUE_DEPTH = 4;

    // White for unmatched crop pixels
    localparam logic [7:0]         CHAN_FULL = 8'd255;
    localparam logic [COLOR_W-1:0] WHITE_RGB = {CHAN_FULL, CHAN_FULL, CHAN_FULL};

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // Classified pixel handed from front to back
    typedef struct packed {
        logic               accum;   // matching measure pixel on the frame
        logic               report;  // last pixel of a measure pass
        logic               crop;    // crop-pass pixel on the frame
        logic               match;   // label equals target colour
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COLOR_W-1:0] image;
    } cmd_t;

endpackage

// ----- rtl/core/lccrc_front.sv -----
// ----------------------------------------------------------------------------
// lccrc_front
// Input side: holds the configuration registers, takes pixels from the input
// queue interface, classifies them and registers one command for the queue.
// Pixels that cause no work are dropped here.
// ----------------------------------------------------------------------------
module lccrc_front #(
    parameter int MAX_WIDTH  = lccrc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = lccrc_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // pixel input
    input  logic                            push,
    output logic                            full,
    input  logic                            kind,
    input  logic [lccrc_pkg::COORD_W-1:0]   pixel_x,
    input  logic [lccrc_pkg::COORD_W-1:0]   pixel_y,
    input  logic [lccrc_pkg::COLOR_W-1:0]   label_color,
    input  logic [lccrc_pkg::COLOR_W-1:0]   image_color,
    input  logic                            last_pixel,
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lccrc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lccrc_pkg::COLOR_W-1:0]   cfg_data,
    output logic [lccrc_pkg::ROI_W-1:0]     roi_width,
    output logic [lccrc_pkg::ROI_W-1:0]     roi_height,
    // command to the queue
    output lccrc_pkg::cmd_t                 cmd,
    output logic                            cmd_valid,
    input  logic                            cmd_ready
);

    localparam int XCLOG = $clog2(MAX_WIDTH + 1);
    localparam int YCLOG = $clog2(MAX_HEIGHT + 1);
    localparam int XCMP_W = (XCLOG > lccrc_pkg::COORD_W) ? XCLOG : lccrc_pkg::COORD_W;
    localparam int YCMP_W = (YCLOG > lccrc_pkg::COORD_W) ? YCLOG : lccrc_pkg::COORD_W;

    logic [lccrc_pkg::COLOR_W-1:0] target_reg;
    logic [lccrc_pkg::ROI_W-1:0]   roi_w_reg;
    logic [lccrc_pkg::ROI_W-1:0]   roi_h_reg;

    logic            valid_reg;
    logic            valid_next;
    lccrc_pkg::cmd_t cmd_reg;
    lccrc_pkg::cmd_t cmd_next;

    logic take;
    logic on_frame;
    logic any_work;

    // Configuration registers: always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
            roi_w_reg  <= lccrc_pkg::ROI_RESET;
            roi_h_reg  <= lccrc_pkg::ROI_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                lccrc_pkg::CFG_TARGET_COLOR: target_reg <= cfg_data;
                lccrc_pkg::CFG_ROI_WIDTH:    roi_w_reg  <= cfg_data[lccrc_pkg::ROI_W-1:0];
                lccrc_pkg::CFG_ROI_HEIGHT:   roi_h_reg  <= cfg_data[lccrc_pkg::ROI_W-1:0];
                default: ;
            endcase
        end
    end

    assign roi_width  = roi_w_reg;
    assign roi_height = roi_h_reg;

    // Classify the incoming pixel
    assign on_frame = (XCMP_W'(pixel_x) < XCMP_W'(MAX_WIDTH)) &&
                      (YCMP_W'(pixel_y) < YCMP_W'(MAX_HEIGHT));

    always_comb
    begin
        cmd_next.match  = (label_color == target_reg);
        cmd_next.accum  = !kind && on_frame && cmd_next.match;
        cmd_next.report = !kind && last_pixel;
        cmd_next.crop   = kind && on_frame;
        cmd_next.x      = pixel_x;
        cmd_next.y      = pixel_y;
        cmd_next.image  = image_color;
    end

    assign any_work = cmd_next.accum || cmd_next.report || cmd_next.crop;
    assign full     = valid_reg && !cmd_ready;
    assign take     = push && !full;

    // Hold the command until the queue takes it
    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = any_work;
        end
        else if (cmd_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg <= cmd_next;
        end
    end

    assign cmd       = cmd_reg;
    assign cmd_valid = valid_reg;

endmodule

// ----- rtl/core/lccrc_queue.sv -----
// ----------------------------------------------------------------------------
// lccrc_queue
// Short command queue between front and back end, so that either side can
// stall without holding up the other.
// ----------------------------------------------------------------------------
module lccrc_queue #(
    parameter int DEPTH = lccrc_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  lccrc_pkg::cmd_t wr_cmd,
    input  logic            wr_valid,
    output logic            wr_ready,
    output lccrc_pkg::cmd_t rd_cmd,
    output logic            rd_valid,
    input  logic            rd_ready
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lccrc_pkg::cmd_t entry_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic do_wr;
    logic do_rd;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;
    assign rd_cmd   = entry_reg[rd_ptr_reg];

    // Advance pointers with wrap at the depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

// ----- rtl/core/lccrc_div.sv -----
// ----------------------------------------------------------------------------
// lccrc_div
// Restoring divider, one quotient bit per cycle. The dividend is a sum of
// coordinates and the divisor their count, so the quotient always fits the
// coordinate width and only those bits are developed.
// ----------------------------------------------------------------------------
module lccrc_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [lccrc_pkg::SUM_W-1:0]   dividend,
    input  logic [lccrc_pkg::CNT_W-1:0]   divisor,
    output logic                          done,
    output logic [lccrc_pkg::QUO_W-1:0]   quotient
);

    localparam int QW   = lccrc_pkg::QUO_W;
    localparam int RW   = lccrc_pkg::CNT_W;
    localparam int STPW = $clog2(QW + 1);

    logic [RW-1:0]   rem_reg;
    logic [RW-1:0]   rem_next;
    logic [QW-1:0]   low_reg;
    logic [QW-1:0]   low_next;
    logic [QW-1:0]   quo_reg;
    logic [QW-1:0]   quo_next;
    logic [STPW-1:0] step_reg;
    logic [STPW-1:0] step_next;
    logic            busy_reg;
    logic            busy_next;
    logic            done_reg;
    logic            done_next;

    logic [RW:0] trial;
    logic [RW:0] diff;
    logic        fits;

    // One trial subtraction per cycle
    assign trial = {rem_reg, low_reg[QW-1]};
    assign diff  = trial - {1'b0, divisor};
    assign fits  = (trial >= {1'b0, divisor});

    always_comb
    begin
        rem_next  = rem_reg;
        low_next  = low_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = RW'(dividend[lccrc_pkg::SUM_W-1:QW]);
            low_next  = dividend[QW-1:0];
            step_next = STPW'(QW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[RW-1:0] : trial[RW-1:0];
            low_next  = {low_reg[QW-2:0], 1'b0};
            quo_next  = {quo_reg[QW-2:0], fits};
            step_next = step_reg - 1'b1;
            if (step_reg == STPW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- rtl/core/lccrc_back.sv -----
// ----------------------------------------------------------------------------
// lccrc_back
// Execution side: takes commands from the queue, keeps the coordinate sums,
// runs the centroid division at the end of a measure pass, tests crop pixels
// against the window and holds the result for the output interface.
// ----------------------------------------------------------------------------
module lccrc_back (
    input  logic                          clk,
    input  logic                          rst_n,
    // command queue head
    input  lccrc_pkg::cmd_t               head,
    input  logic                          head_valid,
    output logic                          head_pop,
    input  logic [lccrc_pkg::ROI_W-1:0]   roi_width,
    input  logic [lccrc_pkg::ROI_W-1:0]   roi_height,
    // divider
    output logic                          div_start,
    output logic [lccrc_pkg::SUM_W-1:0]   div_dividend,
    output logic [lccrc_pkg::CNT_W-1:0]   div_divisor,
    input  logic                          div_done,
    input  logic [lccrc_pkg::QUO_W-1:0]   div_quotient,
    // result output
    output logic                          empty,
    input  logic                          pop,
    output logic                          result_kind,
    output logic                          object_found,
    output logic [lccrc_pkg::COORD_W-1:0] center_x,
    output logic [lccrc_pkg::COORD_W-1:0] center_y,
    output logic [lccrc_pkg::COORD_W-1:0] window_x,
    output logic [lccrc_pkg::COORD_W-1:0] window_y,
    output logic [lccrc_pkg::COLOR_W-1:0] pixel_color
);

    localparam int CW = lccrc_pkg::COORD_W;
    localparam int SW = lccrc_pkg::SUM_W;
    localparam int NW = lccrc_pkg::CNT_W;
    localparam int DW = CW + 2;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LOAD_X = 2'd1;
    localparam logic [1:0] ST_WAIT_X = 2'd2;
    localparam logic [1:0] ST_WAIT_Y = 2'd3;

    logic [1:0]    state_reg;
    logic [1:0]    state_next;
    logic [SW-1:0] sum_x_reg;
    logic [SW-1:0] sum_x_next;
    logic [SW-1:0] sum_y_reg;
    logic [SW-1:0] sum_y_next;
    logic [NW-1:0] count_reg;
    logic [NW-1:0] count_next;
    logic [CW-1:0] cen_x_reg;
    logic [CW-1:0] cen_x_next;
    logic [CW-1:0] cen_y_reg;
    logic [CW-1:0] cen_y_next;
    logic          found_reg;
    logic          found_next;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic                          out_load;
    logic                          kind_reg;
    logic                          kind_next;
    logic                          ofound_reg;
    logic                          ofound_next;
    logic [CW-1:0]                 ocx_reg;
    logic [CW-1:0]                 ocx_next;
    logic [CW-1:0]                 ocy_reg;
    logic [CW-1:0]                 ocy_next;
    logic [CW-1:0]                 owx_reg;
    logic [CW-1:0]                 owx_next;
    logic [CW-1:0]                 owy_reg;
    logic [CW-1:0]                 owy_next;
    logic [lccrc_pkg::COLOR_W-1:0] ocol_reg;
    logic [lccrc_pkg::COLOR_W-1:0] ocol_next;

    logic          need_out;
    logic          can_out;
    logic          acc_ok;
    logic [SW:0]   add_x;
    logic [SW:0]   add_y;
    logic [SW-1:0] sat_x;
    logic [SW-1:0] sat_y;
    logic [NW-1:0] count_after;

    logic [CW-1:0] half_w;
    logic [CW-1:0] half_h;
    logic [DW-1:0] dx;
    logic [DW-1:0] dy;
    logic          in_x;
    logic          in_y;

    // Take the head when idle and, if it may give a result, the slot is free
    assign need_out = head.report || head.crop;
    assign can_out  = !out_valid_reg || pop;
    assign head_pop = (state_reg == ST_IDLE) && head_valid && (!need_out || can_out);

    // Saturating accumulation
    assign acc_ok = head.accum && (count_reg != lccrc_pkg::CNT_MAX);
    assign add_x  = {1'b0, sum_x_reg} + (SW + 1)'(head.x);
    assign add_y  = {1'b0, sum_y_reg} + (SW + 1)'(head.y);
    assign sat_x  = add_x[SW] ? lccrc_pkg::SUM_MAX : add_x[SW-1:0];
    assign sat_y  = add_y[SW] ? lccrc_pkg::SUM_MAX : add_y[SW-1:0];
    assign count_after = acc_ok ? count_reg + 1'b1 : count_reg;

    // Half window sizes, clamped to the ROI limit
    assign half_w = roi_width[lccrc_pkg::ROI_W-1] ? CW'(lccrc_pkg::ROI_LIMIT / 2)
                                                  : CW'(roi_width[lccrc_pkg::ROI_W-2:1]);
    assign half_h = roi_height[lccrc_pkg::ROI_W-1] ? CW'(lccrc_pkg::ROI_LIMIT / 2)
                                                   : CW'(roi_height[lccrc_pkg::ROI_W-2:1]);

    // Offset from window origin; inside when 0 <= offset < twice the half size
    assign dx   = DW'(head.x) - DW'(cen_x_reg) + DW'(half_w);
    assign dy   = DW'(head.y) - DW'(cen_y_reg) + DW'(half_h);
    assign in_x = !dx[DW-1] && (dx[DW-2:0] < {half_w, 1'b0});
    assign in_y = !dy[DW-1] && (dy[DW-2:0] < {half_h, 1'b0});

    assign div_divisor = count_reg;

    always_comb
    begin
        state_next   = state_reg;
        sum_x_next   = sum_x_reg;
        sum_y_next   = sum_y_reg;
        count_next   = count_reg;
        cen_x_next   = cen_x_reg;
        cen_y_next   = cen_y_reg;
        found_next   = found_reg;
        div_start    = 1'b0;
        div_dividend = sum_x_reg;
        out_load     = 1'b0;
        kind_next    = kind_reg;
        ofound_next  = ofound_reg;
        ocx_next     = ocx_reg;
        ocy_next     = ocy_reg;
        owx_next     = owx_reg;
        owy_next     = owy_reg;
        ocol_next    = ocol_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (head_pop)
                begin
                    if (acc_ok)
                    begin
                        sum_x_next = sat_x;
                        sum_y_next = sat_y;
                        count_next = count_after;
                    end
                    if (head.report)
                    begin
                        if (count_after == '0)
                        begin
                            // No match in this pass: report at once
                            cen_x_next  = '0;
                            cen_y_next  = '0;
                            found_next  = 1'b0;
                            out_load    = 1'b1;
                            kind_next   = 1'b0;
                            ofound_next = 1'b0;
                            ocx_next    = '0;
                            ocy_next    = '0;
                            owx_next    = '0;
                            owy_next    = '0;
                            ocol_next   = '0;
                        end
                        else
                        begin
                            state_next = ST_LOAD_X;
                        end
                    end
                    if (head.crop && found_reg && in_x && in_y)
                    begin
                        out_load    = 1'b1;
                        kind_next   = 1'b1;
                        ofound_next = 1'b1;
                        ocx_next    = cen_x_reg;
                        ocy_next    = cen_y_reg;
                        owx_next    = dx[CW-1:0];
                        owy_next    = dy[CW-1:0];
                        ocol_next   = head.match ? head.image : lccrc_pkg::WHITE_RGB;
                    end
                end
            end
            ST_LOAD_X:
            begin
                div_start    = 1'b1;
                div_dividend = sum_x_reg;
                state_next   = ST_WAIT_X;
            end
            ST_WAIT_X:
            begin
                if (div_done)
                begin
                    cen_x_next   = div_quotient;
                    div_start    = 1'b1;
                    div_dividend = sum_y_reg;
                    state_next   = ST_WAIT_Y;
                end
            end
            ST_WAIT_Y:
            begin
                if (div_done)
                begin
                    // Latch centroid, report it and clear the sums
                    cen_y_next  = div_quotient;
                    found_next  = 1'b1;
                    sum_x_next  = '0;
                    sum_y_next  = '0;
                    count_next  = '0;
                    out_load    = 1'b1;
                    kind_next   = 1'b0;
                    ofound_next = 1'b1;
                    ocx_next    = cen_x_reg;
                    ocy_next    = div_quotient;
                    owx_next    = '0;
                    owy_next    = '0;
                    ocol_next   = '0;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result slot: load overrides drain
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            count_reg     <= '0;
            cen_x_reg     <= '0;
            cen_y_reg     <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_x_reg     <= sum_x_next;
            sum_y_reg     <= sum_y_next;
            count_reg     <= count_next;
            cen_x_reg     <= cen_x_next;
            cen_y_reg     <= cen_y_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        ofound_reg <= ofound_next;
        ocx_reg    <= ocx_next;
        ocy_reg    <= ocy_next;
        owx_reg    <= owx_next;
        owy_reg    <= owy_next;
        ocol_reg   <= ocol_next;
    end

    assign empty        = !out_valid_reg;
    assign result_kind  = kind_reg;
    assign object_found = ofound_reg;
    assign center_x     = ocx_reg;
    assign center_y     = ocy_reg;
    assign window_x     = owx_reg;
    assign window_y     = owy_reg;
    assign pixel_color  = ocol_reg;

endmodule

// ----- rtl/core/label_centroid_roi_crop_core.sv -----
// ----------------------------------------------------------------------------
// label_centroid_roi_crop_core
// Blob centroid and ROI crop over a frame streamed twice in raster order.
// ----------------------------------------------------------------------------
// Pixels are taken at one per clock: a front register and a four-entry
// command queue let the input run on while the result register waits to be
// popped. Measure-pass pixels give no result; the last one of a pass gives a
// centroid report once one shared restoring divider, which develops one
// quotient bit a cycle, has run first for the column then for the row.
// Crop-pass pixels inside the window give one result each, loaded into the
// result register as the back end takes them from the queue head. Input
// stalls (full) only when the queue fills, during the division or while
// results are not popped. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module label_centroid_roi_crop_core #(
    parameter int MAX_WIDTH  = lccrc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = lccrc_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // pixel input
    input  logic                            push,
    output logic                            full,
    input  logic                            kind,
    input  logic [lccrc_pkg::COORD_W-1:0]   pixel_x,
    input  logic [lccrc_pkg::COORD_W-1:0]   pixel_y,
    input  logic [lccrc_pkg::COLOR_W-1:0]   label_color,
    input  logic [lccrc_pkg::COLOR_W-1:0]   image_color,
    input  logic                            last_pixel,
    // results
    output logic                            empty,
    input  logic                            pop,
    output logic                            result_kind,
    output logic                            object_found,
    output logic [lccrc_pkg::COORD_W-1:0]   center_x,
    output logic [lccrc_pkg::COORD_W-1:0]   center_y,
    output logic [lccrc_pkg::COORD_W-1:0]   window_x,
    output logic [lccrc_pkg::COORD_W-1:0]   window_y,
    output logic [lccrc_pkg::COLOR_W-1:0]   pixel_color,
    // configuration
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lccrc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lccrc_pkg::COLOR_W-1:0]   cfg_data
);

    lccrc_pkg::cmd_t front_cmd;
    logic            front_valid;
    logic            queue_ready;
    lccrc_pkg::cmd_t head_cmd;
    logic            head_valid;
    logic            head_pop;

    logic [lccrc_pkg::ROI_W-1:0]   roi_width;
    logic [lccrc_pkg::ROI_W-1:0]   roi_height;
    logic                          div_start;
    logic [lccrc_pkg::SUM_W-1:0]   div_dividend;
    logic [lccrc_pkg::CNT_W-1:0]   div_divisor;
    logic                          div_done;
    logic [lccrc_pkg::QUO_W-1:0]   div_quotient;

    lccrc_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .kind        (kind),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .label_color (label_color),
        .image_color (image_color),
        .last_pixel  (last_pixel),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .roi_width   (roi_width),
        .roi_height  (roi_height),
        .cmd         (front_cmd),
        .cmd_valid   (front_valid),
        .cmd_ready   (queue_ready)
    );

    lccrc_queue #(
        .DEPTH (lccrc_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_cmd   (front_cmd),
        .wr_valid (front_valid),
        .wr_ready (queue_ready),
        .rd_cmd   (head_cmd),
        .rd_valid (head_valid),
        .rd_ready (head_pop)
    );

    lccrc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    lccrc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head_cmd),
        .head_valid   (head_valid),
        .head_pop     (head_pop),
        .roi_width    (roi_width),
        .roi_height   (roi_height),
        .div_start    (div_start),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_done     (div_done),
        .div_quotient (div_quotient),
        .empty        (empty),
        .pop          (pop),
        .result_kind  (result_kind),
        .object_found (object_found),
        .center_x     (center_x),
        .center_y     (center_y),
        .window_x     (window_x),
        .window_y     (window_y),
        .pixel_color  (pixel_color)
    );

endmodule

// ----- rtl/core/lccrc_checker.sv -----
// ----------------------------------------------------------------------------
// lccrc_checker
// Port-level checks on the result stream of the crop core, bound to the top.
// ----------------------------------------------------------------------------
module lccrc_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            empty,
    input logic                            pop,
    input logic                            result_kind,
    input logic                            object_found,
    input logic [lccrc_pkg::COORD_W-1:0]   center_x,
    input logic [lccrc_pkg::COORD_W-1:0]   center_y,
    input logic [lccrc_pkg::COORD_W-1:0]   window_x,
    input logic [lccrc_pkg::COORD_W-1:0]   window_y,
    input logic [lccrc_pkg::COLOR_W-1:0]   pixel_color
);

    // A cropped pixel only appears once an object was found
    a_crop_needs_object: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result_kind) |-> object_found)
        else $error("crop result without a found object");

    // A report of no object carries a zero centroid
    a_empty_report_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result_kind && !object_found) |-> (center_x == '0 && center_y == '0))
        else $error("no-object report with nonzero centroid");

    // A centroid report carries no window position and no colour
    a_report_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result_kind) |-> (window_x == '0 && window_y == '0 && pixel_color == '0))
        else $error("centroid report with window fields set");

    // Hold a waiting result until it is popped
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(pixel_color) && $stable(center_x)))
        else $error("waiting result changed or vanished");

endmodule

bind label_centroid_roi_crop_core lccrc_checker u_lccrc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .empty        (empty),
    .pop          (pop),
    .result_kind  (result_kind),
    .object_found (object_found),
    .center_x     (center_x),
    .center_y     (center_y),
    .window_x     (window_x),
    .window_y     (window_y),
    .pixel_color  (pixel_color)
);

// ----- bench/label_centroid_roi_crop_core_test.sv -----
// ----------------------------------------------------------------------------
// label_centroid_roi_crop_core_test
// Self-checking bench for the blob centroid and ROI crop core. A table of
// directed pixels and register writes runs first. Random frames follow:
// measure passes, crop passes, truncated passes and stray pixels, with random
// gaps on the pixel side and random stalls on the result side. Every popped
// result is checked against the directed table's expectation or this bench's predictor.
// ----------------------------------------------------------------------------
module label_centroid_roi_crop_core_test;

    // Widths and constants shared with the core
    localparam int                         COORD_W        = lccrc_pkg::COORD_W;
    localparam int                         COLOR_W        = lccrc_pkg::COLOR_W;
    localparam int                         ROI_W          = lccrc_pkg::ROI_W;
    localparam int                         SUM_W          = lccrc_pkg::SUM_W;
    localparam int                         CNT_W          = lccrc_pkg::CNT_W;
    localparam int                         CFG_IDX_W      = lccrc_pkg::CFG_IDX_W;
    localparam int                         ROI_LIMIT      = lccrc_pkg::ROI_LIMIT;
    localparam int                         DEF_MAX_WIDTH  = lccrc_pkg::DEF_MAX_WIDTH;
    localparam int                         DEF_MAX_HEIGHT = lccrc_pkg::DEF_MAX_HEIGHT;
    localparam logic [lccrc_pkg::ROI_W-1:0]   ROI_RESET   = lccrc_pkg::ROI_RESET;
    localparam logic [lccrc_pkg::COLOR_W-1:0] WHITE_RGB   = lccrc_pkg::WHITE_RGB;
    localparam logic [lccrc_pkg::CNT_W-1:0]   CNT_MAX     = lccrc_pkg::CNT_MAX;
    localparam logic [lccrc_pkg::SUM_W-1:0]   SUM_MAX     = lccrc_pkg::SUM_MAX;

    // Pixel and result kinds
    localparam bit MEASURE    = 1'b0;
    localparam bit CROP       = 1'b1;
    localparam bit REPORT     = 1'b0;
    localparam bit CROP_PIXEL = 1'b1;

    localparam int ITEM_TARGET   = 900;
    localparam int SETTLE_CYCLES = 64;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        bit               kind;
        bit [COORD_W-1:0] x;
        bit [COORD_W-1:0] y;
        bit [COLOR_W-1:0] label;
        bit [COLOR_W-1:0] image;
        bit               final_px;
    } pixel_t;

    typedef struct packed {
        logic               kind;
        logic               found;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [COORD_W-1:0] wx;
        logic [COORD_W-1:0] wy;
        logic [COLOR_W-1:0] color;
    } blob_out_t;

    typedef struct packed {
        bit                 is_reg;
        bit [CFG_IDX_W-1:0] reg_idx;
        bit [COLOR_W-1:0]   reg_val;
        pixel_t             px;
        bit                 typed;
        blob_out_t          want;
    } step_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 full;
    logic                 kind = 1'b0;
    logic [COORD_W-1:0]   pixel_x = '0;
    logic [COORD_W-1:0]   pixel_y = '0;
    logic [COLOR_W-1:0]   label_color = '0;
    logic [COLOR_W-1:0]   image_color = '0;
    logic                 last_pixel = 1'b0;
    logic                 empty;
    logic                 pop = 1'b0;
    logic                 result_kind;
    logic                 object_found;
    logic [COORD_W-1:0]   center_x;
    logic [COORD_W-1:0]   center_y;
    logic [COORD_W-1:0]   window_x;
    logic [COORD_W-1:0]   window_y;
    logic [COLOR_W-1:0]   pixel_color;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COLOR_W-1:0]   cfg_data = '0;

    // Predictor copy of registers and state
    bit [COLOR_W-1:0] tgt_color;
    bit [ROI_W-1:0]   roi_w;
    bit [ROI_W-1:0]   roi_h;
    bit [SUM_W-1:0]   col_sum;
    bit [SUM_W-1:0]   row_sum;
    bit [CNT_W-1:0]   hit_cnt;
    bit [COORD_W-1:0] cen_x;
    bit [COORD_W-1:0] cen_y;
    bit               blob_seen;

    blob_out_t crop_and_centroid_q [$];
    step_row_t dir_rows [$];
    blob_out_t got_out;
    blob_out_t want_out;

    bit steady = 1'b0;
    int stall_left = 0;
    int fail_cnt = 0;
    int items = 0;
    int frames = 0;
    int reports_seen = 0;
    int crops_seen = 0;
    int reg_writes = 0;
    int cycle_cnt = 0;

    label_centroid_roi_crop_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .kind         (kind),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .label_color  (label_color),
        .image_color  (image_color),
        .last_pixel   (last_pixel),
        .empty        (empty),
        .pop          (pop),
        .result_kind  (result_kind),
        .object_found (object_found),
        .center_x     (center_x),
        .center_y     (center_y),
        .window_x     (window_x),
        .window_y     (window_y),
        .pixel_color  (pixel_color),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Mostly short gaps, now and then a long one, none in steady stretches
    function automatic int pick_gap();
        int roll;
        if (steady)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Advance the blob state by one pixel and work out its result, if any
    function automatic bit track_blob(input pixel_t p, output blob_out_t r);
        bit             on_frame;
        bit             hit;
        bit [SUM_W:0]   s;
        bit [SUM_W-1:0] q;
        int             hw;
        int             hh;
        int             left;
        int             top;
        int             dx;
        int             dy;
        r = '0;
        on_frame = (int'(p.x) < DEF_MAX_WIDTH) && (int'(p.y) < DEF_MAX_HEIGHT);
        hit = (p.label == tgt_color);
        if (p.kind == MEASURE)
        begin
            if (on_frame && hit && hit_cnt != CNT_MAX)
            begin
                s = {1'b0, col_sum} + (SUM_W + 1)'(p.x);
                col_sum = (s > SUM_MAX) ? SUM_MAX : s[SUM_W-1:0];
                s = {1'b0, row_sum} + (SUM_W + 1)'(p.y);
                row_sum = (s > SUM_MAX) ? SUM_MAX : s[SUM_W-1:0];
                hit_cnt = hit_cnt + 1'b1;
            end
            if (!p.final_px)
                return 1'b0;
            if (hit_cnt != 0)
            begin
                q = col_sum / hit_cnt;
                cen_x = q[COORD_W-1:0];
                q = row_sum / hit_cnt;
                cen_y = q[COORD_W-1:0];
                blob_seen = 1'b1;
            end
            else
            begin
                cen_x = '0;
                cen_y = '0;
                blob_seen = 1'b0;
            end
            col_sum = '0;
            row_sum = '0;
            hit_cnt = '0;
            r.kind = REPORT;
            r.found = blob_seen;
            r.cx = cen_x;
            r.cy = cen_y;
            return 1'b1;
        end
        if (!blob_seen || !on_frame)
            return 1'b0;
        // Window spans twice the halved size, clamped at the ROI limit
        hw = ((roi_w > ROI_LIMIT) ? ROI_LIMIT : int'(roi_w)) / 2;
        hh = ((roi_h > ROI_LIMIT) ? ROI_LIMIT : int'(roi_h)) / 2;
        left = int'(cen_x) - hw;
        top = int'(cen_y) - hh;
        dx = int'(p.x) - left;
        dy = int'(p.y) - top;
        if (dx < 0 || dx >= 2 * hw || dy < 0 || dy >= 2 * hh)
            return 1'b0;
        r.kind = CROP_PIXEL;
        r.found = 1'b1;
        r.cx = cen_x;
        r.cy = cen_y;
        r.wx = dx[COORD_W-1:0];
        r.wy = dy[COORD_W-1:0];
        r.color = hit ? p.image : WHITE_RGB;
        return 1'b1;
    endfunction

    function automatic pixel_t pix(bit k, int x, int y, bit [23:0] lab, bit [23:0] img,
                                   bit fin);
        pixel_t p;
        p.kind = k;
        p.x = x[COORD_W-1:0];
        p.y = y[COORD_W-1:0];
        p.label = lab;
        p.image = img;
        p.final_px = fin;
        return p;
    endfunction

    function automatic blob_out_t rep(bit fnd, int cx, int cy);
        return {REPORT, fnd, cx[COORD_W-1:0], cy[COORD_W-1:0], 11'd0, 11'd0, 24'd0};
    endfunction

    function automatic blob_out_t crp(int cx, int cy, int wx, int wy, bit [23:0] col);
        return {CROP_PIXEL, 1'b1, cx[COORD_W-1:0], cy[COORD_W-1:0], wx[COORD_W-1:0],
                wy[COORD_W-1:0], col};
    endfunction

    function automatic step_row_t px_row(pixel_t p, bit typed, blob_out_t w);
        return {1'b0, {CFG_IDX_W{1'b0}}, 24'd0, p, typed, w};
    endfunction

    function automatic step_row_t reg_row(bit [CFG_IDX_W-1:0] idx, bit [23:0] val);
        return {1'b1, idx, val, pixel_t'('0), 1'b0, blob_out_t'('0)};
    endfunction

    // Append one row to the directed table
    function automatic void add_row(input step_row_t row);
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    // Offer one pixel, hold it until the transfer, then leave a random gap
    task automatic send_pixel(input pixel_t p, input bit typed, input blob_out_t w);
        blob_out_t r;
        int        g;
        @(negedge clk);
        push <= 1'b1;
        kind <= p.kind;
        pixel_x <= p.x;
        pixel_y <= p.y;
        label_color <= p.label;
        image_color <= p.image;
        last_pixel <= p.final_px;
        do
            @(posedge clk);
        while (full);
        items++;
        if (track_blob(p, r))
            crop_and_centroid_q.insert(crop_and_centroid_q.size(), typed ? w : r);
        g = pick_gap();
        if (g > 0)
        begin
            @(negedge clk);
            push <= 1'b0;
            repeat (g - 1) @(negedge clk);
        end
    endtask

    // Drop push, wait for every result owed, then let the divider run dry
    task automatic settle();
        int waited;
        @(negedge clk);
        push <= 1'b0;
        waited = 0;
        while (crop_and_centroid_q.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        if (crop_and_centroid_q.size() != 0)
        begin
            $display("results never arrived: %0d", crop_and_centroid_q.size());
            fail_cnt += crop_and_centroid_q.size();
            crop_and_centroid_q.delete();
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input bit [CFG_IDX_W-1:0] idx, input bit [COLOR_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            lccrc_pkg::CFG_TARGET_COLOR: tgt_color = val;
            lccrc_pkg::CFG_ROI_WIDTH:    roi_w = val[ROI_W-1:0];
            lccrc_pkg::CFG_ROI_HEIGHT:   roi_h = val[ROI_W-1:0];
            default: ;
        endcase
        reg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic bit [COLOR_W-1:0] stray_color();
        if ($urandom_range(0, 2) == 0)
            return tgt_color ^ (24'd1 << $urandom_range(0, 23));
        return 24'($urandom);
    endfunction

    function automatic bit [COLOR_W-1:0] pick_roi();
        bit [ROI_W-1:0] v;
        case ($urandom_range(0, 19))
            0:       v = 12'd0;
            1:       v = 12'd1;
            2:       v = 12'd2048;
            3:       v = 12'd4095;
            4:       v = 12'($urandom_range(2049, 4095));
            5:       v = 12'($urandom);
            default: v = 12'($urandom_range(2, 26));
        endcase
        // Upper data bits carry junk now and then
        if ($urandom_range(0, 3) == 0)
            return {12'($urandom), v};
        return {12'd0, v};
    endfunction

    task automatic shuffle_regs();
        bit [COLOR_W-1:0] v;
        settle();
        if ($urandom_range(0, 1) == 0)
        begin
            case ($urandom_range(0, 3))
                0:       v = 24'd0;
                1:       v = 24'hFFFFFF;
                default: v = 24'($urandom);
            endcase
            write_reg(lccrc_pkg::CFG_TARGET_COLOR, v);
        end
        if ($urandom_range(0, 1) == 0)
            write_reg(lccrc_pkg::CFG_ROI_WIDTH, pick_roi());
        if ($urandom_range(0, 1) == 0)
            write_reg(lccrc_pkg::CFG_ROI_HEIGHT, pick_roi());
    endtask

    // Measure pass then crop pass over one small frame, sometimes broken
    task automatic run_frame();
        int     w;
        int     h;
        int     ox;
        int     oy;
        int     hit_pct;
        int     sent;
        int     n;
        bit     fin;
        pixel_t p;
        w = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 6);
        h = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 6);
        case ($urandom_range(0, 3))
            0:       ox = 0;
            1:       ox = DEF_MAX_WIDTH - w;
            default: ox = $urandom_range(0, DEF_MAX_WIDTH - w);
        endcase
        case ($urandom_range(0, 3))
            0:       oy = 0;
            1:       oy = DEF_MAX_HEIGHT - h;
            default: oy = $urandom_range(0, DEF_MAX_HEIGHT - h);
        endcase
        hit_pct = $urandom_range(0, 100);
        sent = ($urandom_range(0, 11) == 0) ? $urandom_range(0, w * h - 1) : w * h;
        for (n = 0; n < sent; n++)
        begin
            fin = (n == w * h - 1);
            p = pix(MEASURE, ox + n % w, oy + n / w,
                    ($urandom_range(0, 99) < hit_pct) ? tgt_color : stray_color(),
                    24'($urandom), fin);
            send_pixel(p, 1'b0, '0);
        end
        if ($urandom_range(0, 7) != 0)
        begin
            for (n = 0; n < w * h; n++)
            begin
                fin = (n == w * h - 1);
                p = pix(CROP, ox + n % w, oy + n / w,
                        ($urandom_range(0, 99) < hit_pct) ? tgt_color : stray_color(),
                        24'($urandom), fin);
                send_pixel(p, 1'b0, '0);
            end
        end
        frames++;
    endtask

    // Result side: pop with random stalls
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            pop <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            pop <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    // Check each popped transfer against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            got_out = {result_kind, object_found, center_x, center_y, window_x, window_y,
                       pixel_color};
            if (crop_and_centroid_q.size() == 0)
            begin
                if (fail_cnt < REPORT_LIMIT)
                    $display("unexpected result: kind %0d found %0d c(%0d,%0d) w(%0d,%0d) %h",
                             got_out.kind, got_out.found, got_out.cx, got_out.cy,
                             got_out.wx, got_out.wy, got_out.color);
                fail_cnt++;
            end
            else
            begin
                want_out = crop_and_centroid_q.pop_front();
                if (got_out !== want_out)
                begin
                    if (fail_cnt < REPORT_LIMIT)
                        $display({"mismatch: exp kind %0d found %0d c(%0d,%0d) w(%0d,%0d) %h",
                                  " / got kind %0d found %0d c(%0d,%0d) w(%0d,%0d) %h"},
                                 want_out.kind, want_out.found, want_out.cx, want_out.cy,
                                 want_out.wx, want_out.wy, want_out.color,
                                 got_out.kind, got_out.found, got_out.cx, got_out.cy,
                                 got_out.wx, got_out.wy, got_out.color);
                    fail_cnt++;
                end
                else if (want_out.kind == REPORT)
                    reports_seen++;
                else
                    crops_seen++;
            end
        end
    end

    // Guard against a hung handshake
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        int i;
        tgt_color = '0;
        roi_w = ROI_RESET;
        roi_h = ROI_RESET;
        col_sum = '0;
        row_sum = '0;
        hit_cnt = '0;
        cen_x = '0;
        cen_y = '0;
        blob_seen = 1'b0;

        // Directed table: reset defaults are target 0 and a 100 by 100 window
        add_row(px_row(pix(CROP, 5, 5, 24'h0, 24'h0, 0), 0, '0));
        add_row(px_row(pix(MEASURE, 2047, 2047, 24'hFFFFFF, 24'hFFFFFF, 1), 1,
                       rep(0, 0, 0)));
        add_row(px_row(pix(CROP, 0, 0, 24'h0, 24'h0, 0), 0, '0));
        add_row(px_row(pix(MEASURE, 0, 0, 24'h0, 24'hFFFFFF, 0), 0, '0));
        add_row(px_row(pix(MEASURE, 2047, 2047, 24'h0, 24'h0, 1), 1,
                       rep(1, 1023, 1023)));
        add_row(px_row(pix(CROP, 973, 973, 24'h0, 24'hABCDEF, 0), 1,
                       crp(1023, 1023, 0, 0, 24'hABCDEF)));
        add_row(px_row(pix(CROP, 1072, 1072, 24'h1, 24'h123456, 0), 1,
                       crp(1023, 1023, 99, 99, WHITE_RGB)));
        add_row(px_row(pix(CROP, 1073, 1000, 24'h0, 24'h0, 0), 0, '0));
        add_row(px_row(pix(CROP, 1000, 972, 24'h0, 24'h0, 0), 0, '0));
        add_row(px_row(pix(CROP, 1000, 1000, 24'h0, 24'h0, 1), 1,
                       crp(1023, 1023, 27, 27, 24'h0)));
        add_row(px_row(pix(MEASURE, 0, 0, 24'h0, 24'h0, 1), 1, rep(1, 0, 0)));
        add_row(px_row(pix(CROP, 0, 0, 24'h0, 24'h123456, 0), 1,
                       crp(0, 0, 50, 50, 24'h123456)));
        add_row(px_row(pix(CROP, 49, 49, 24'h7, 24'h0, 0), 1,
                       crp(0, 0, 99, 99, WHITE_RGB)));
        // Oversized width, odd height, all-ones target
        add_row(reg_row(lccrc_pkg::CFG_ROI_WIDTH, 24'd4095));
        add_row(reg_row(lccrc_pkg::CFG_ROI_HEIGHT, 24'd7));
        add_row(reg_row(lccrc_pkg::CFG_TARGET_COLOR, 24'hFFFFFF));
        add_row(px_row(pix(MEASURE, 2047, 0, 24'hFFFFFF, 24'h0, 0), 0, '0));
        add_row(px_row(pix(MEASURE, 2047, 2047, 24'hFFFFFF, 24'h0, 0), 0, '0));
        add_row(px_row(pix(MEASURE, 0, 1024, 24'h0, 24'h0, 1), 1,
                       rep(1, 2047, 1023)));
        add_row(px_row(pix(CROP, 2047, 1020, 24'hFFFFFF, 24'h00FF00, 0), 1,
                       crp(2047, 1023, 1024, 0, 24'h00FF00)));
        add_row(px_row(pix(CROP, 1500, 1026, 24'hFFFFFF, 24'h0, 0), 0, '0));
        // Empty windows
        add_row(reg_row(lccrc_pkg::CFG_ROI_WIDTH, 24'd0));
        add_row(px_row(pix(CROP, 2047, 1023, 24'hFFFFFF, 24'h0, 0), 0, '0));
        add_row(reg_row(lccrc_pkg::CFG_ROI_WIDTH, 24'd2048));
        add_row(reg_row(lccrc_pkg::CFG_ROI_HEIGHT, 24'd0));
        add_row(px_row(pix(CROP, 2047, 1023, 24'hFFFFFF, 24'h0, 1), 0, '0));

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < dir_rows.size(); i++)
        begin
            if (dir_rows[i].is_reg)
            begin
                settle();
                write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
            end
            else
                send_pixel(dir_rows[i].px, dir_rows[i].typed, dir_rows[i].want);
        end

        // Random frames with stray pixels and register changes in between
        while (items < ITEM_TARGET)
        begin
            steady = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 2) == 0)
                shuffle_regs();
            if ($urandom_range(0, 2) == 0)
            begin
                repeat ($urandom_range(1, 4))
                    send_pixel(pix(1'($urandom_range(0, 1)), $urandom_range(0, 2047),
                                   $urandom_range(0, 2047),
                                   ($urandom_range(0, 1) == 0) ? tgt_color : 24'($urandom),
                                   24'($urandom), 1'($urandom_range(0, 1))), 1'b0, '0);
            end
            run_frame();
        end

        steady = 1'b0;
        settle();
        $display("covered %0d pixels over %0d random frames and %0d register writes",
                 items, frames, reg_writes);
        $display("checked %0d centroid reports and %0d cropped pixels",
                 reports_seen, crops_seen);
        if (fail_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- label_centroid_roi_crop_core.f -----
rtl/core/lccrc_pkg.sv
rtl/core/lccrc_front.sv
rtl/core/lccrc_queue.sv
rtl/core/lccrc_div.sv
rtl/core/lccrc_back.sv
rtl/core/label_centroid_roi_crop_core.sv
rtl/core/lccrc_checker.sv
bench/label_centroid_roi_crop_core_test.sv
